// ===== hdl/ffra_pkg.sv =====
package ffra_pkg;

	localparam int unsigned SLOT_W = 16;
	localparam int unsigned HEAP_W = 20;
	localparam int unsigned INC_W  = 9;
	localparam int unsigned OFF_W  = 29;
	localparam int unsigned ENT_W  = 2 * SLOT_W;
	localparam int unsigned ADDR_W = 4;

	typedef enum logic [1:0] {
		ST_ALLOC_OK   = 2'd0,
		ST_ALLOC_FAIL = 2'd1,
		ST_RELEASED   = 2'd2,
		ST_DROPPED    = 2'd3
	} status_t;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] REG_POOL_SIZE = 2'd0;
	localparam logic [1:0] REG_HEAP_OFF  = 2'd1;
	localparam logic [1:0] REG_INC_SIZE  = 2'd2;

	localparam logic [INC_W-1:0] INC_RESET = 9'd32;

endpackage

// ===== hdl/ffra_ram.sv =====
module ffra_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/first_fit_range_allocator_top.sv =====
// Channel  | handshake             | payload
// req      | req_valid / req_stall | cmd, req_head, req_size
// rsp      | rsp_valid / rsp_stall | status, block_head, block_size, byte_offset
// cfg      | APB write/read        | pool_size, heap_offset, increment_size
//
// One request at a time. The free table lives in one RAM; a scan reads one entry
// a cycle, and a table shift moves each entry with a read and then a write back.
// A zero-size request skips the scan and goes straight to the response.
// After reset, S_INIT writes the single empty range; a pool_size write rebuilds it.
// req_stall is high while a request is in work; a waiting response holds in the
// output register and the sequencer waits before loading the next one.
module first_fit_range_allocator_top
	import ffra_pkg::*;
#(
	parameter int unsigned MAX_FREE_RANGES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              cmd,
	input  logic [SLOT_W-1:0] req_head,
	input  logic [SLOT_W-1:0] req_size,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] block_head,
	output logic [SLOT_W-1:0] block_size,
	output logic [OFF_W-1:0]  byte_offset
);

	localparam int unsigned AW = $clog2(MAX_FREE_RANGES);
	localparam int unsigned CW = $clog2(MAX_FREE_RANGES + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_RANGES);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SCAN, S_DEC, S_SHDN_RD, S_SHDN_WR, S_SHUP_RD, S_SHUP_WR, S_RESP
	} state_t;

	state_t state_q;

	logic [SLOT_W-1:0] pool_q;
	logic [HEAP_W-1:0] heap_q;
	logic [INC_W-1:0]  inc_q;

	logic [CW-1:0] count_q, idx_q, ridx_s1, pos_q, j_q;
	logic          vld_s1;
	logic          cmd_q;
	logic [SLOT_W-1:0] head_q, size_q;
	logic [SLOT_W-1:0] prev_start_q, prev_len_q, next_start_q, next_len_q;
	logic          have_prev_q, have_next_q;
	status_t       res_st_q;
	logic [SLOT_W-1:0] res_head_q, res_size_q;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [ENT_W-1:0] wdata, rdata;

	logic cfg_wr, pool_wr;
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign pool_wr = cfg_wr && (paddr[3:2] == REG_POOL_SIZE);

	// register read back
	always_comb begin
		case (paddr[3:2])
			REG_POOL_SIZE: prdata = {16'd0, pool_q};
			REG_HEAP_OFF:  prdata = {12'd0, heap_q};
			REG_INC_SIZE:  prdata = {23'd0, inc_q};
			default:       prdata = 32'd0;
		endcase
	end

	// entry fields of the read data
	logic [SLOT_W-1:0] ent_start, ent_len;
	assign ent_start = rdata[ENT_W-1:SLOT_W];
	assign ent_len   = rdata[SLOT_W-1:0];

	logic scan_issue, alloc_hit, rel_found, scan_end;
	logic [SLOT_W-1:0] alloc_rem;
	assign scan_issue = (state_q == S_SCAN) && (idx_q < count_q) && !alloc_hit && !rel_found;
	assign alloc_hit  = (state_q == S_SCAN) && vld_s1 && (cmd_q == CMD_ALLOC) && (size_q <= ent_len);
	assign rel_found  = (state_q == S_SCAN) && vld_s1 && (cmd_q == CMD_RELEASE)
		&& (ent_start >= head_q);
	assign scan_end   = (state_q == S_SCAN) && !vld_s1 && (idx_q >= count_q);
	assign alloc_rem  = ent_len - size_q;

	// merge decision from the neighbors found by the scan
	logic [SLOT_W:0]   next_sum, total, prev_end;
	logic [SLOT_W+1:0] prev_sum;
	logic              with_next, with_prev;
	logic [CW-1:0]     pos_m1;
	assign next_sum  = {1'b0, size_q} + {1'b0, next_len_q};
	assign with_next = have_next_q && (({1'b0, head_q} + {1'b0, size_q}) == {1'b0, next_start_q})
		&& (next_sum <= 17'h0FFFF);
	assign total     = with_next ? next_sum : {1'b0, size_q};
	assign prev_end  = {1'b0, prev_start_q} + {1'b0, prev_len_q};
	assign prev_sum  = {2'b0, prev_len_q} + {1'b0, total};
	assign with_prev = have_prev_q && (prev_end == {1'b0, head_q}) && (prev_sum <= 18'h0FFFF);
	assign pos_m1    = pos_q - CW'(1);

	logic [CW-1:0] j_p1, j_m1;
	assign j_p1 = j_q + CW'(1);
	assign j_m1 = j_q - CW'(1);

	// table RAM ports
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			S_INIT, S_IDLE: begin
				// write the single range after reset or on a pool_size write
				if (state_q == S_INIT || pool_wr) begin
					we    = 1'b1;
					wdata = {16'd0, pool_wr ? pwdata[15:0] : pool_q};
				end
			end
			S_SCAN: begin
				re    = scan_issue;
				raddr = idx_q[AW-1:0];
				if (alloc_hit && alloc_rem != '0) begin
					we    = 1'b1;
					waddr = ridx_s1[AW-1:0];
					wdata = {ent_start + size_q, alloc_rem};
				end
			end
			S_DEC: begin
				if (with_prev) begin
					we    = 1'b1;
					waddr = pos_m1[AW-1:0];
					wdata = {prev_start_q, prev_sum[SLOT_W-1:0]};
				end else if (with_next) begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = {head_q, total[SLOT_W-1:0]};
				end
			end
			S_SHDN_RD: begin
				re    = j_p1 < count_q;
				raddr = j_p1[AW-1:0];
			end
			S_SHDN_WR, S_SHUP_WR: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				wdata = rdata;
			end
			S_SHUP_RD: begin
				if (j_q > pos_q) begin
					re    = 1'b1;
					raddr = j_m1[AW-1:0];
				end else begin
					we    = 1'b1;
					waddr = pos_q[AW-1:0];
					wdata = {head_q, size_q};
				end
			end
			default: begin
			end
		endcase
	end

	ffra_ram #(.WIDTH(ENT_W), .DEPTH(MAX_FREE_RANGES)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign req_stall = (state_q != S_IDLE);

	// clip a release so that it ends at the top of the slot space
	logic [SLOT_W:0] req_end;
	assign req_end = {1'b0, req_head} + {1'b0, req_size};

	logic [HEAP_W:0]       off_sum;
	logic [HEAP_W+INC_W:0] off_prod;
	assign off_sum  = {1'b0, heap_q} + (HEAP_W+1)'(res_head_q);
	assign off_prod = off_sum * inc_q;

	// sequencer, config registers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pool_q      <= '0;
			heap_q      <= '0;
			inc_q       <= INC_RESET;
			count_q     <= CW'(1);
			vld_s1      <= 1'b0;
			rsp_valid   <= 1'b0;
			have_prev_q <= 1'b0;
			have_next_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			// drop a taken response unless the next one loads now
			if (rsp_valid && !rsp_stall && state_q != S_RESP) begin
				rsp_valid <= 1'b0;
			end
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_POOL_SIZE: begin
						pool_q  <= pwdata[15:0];
						count_q <= CW'(1);
					end
					REG_HEAP_OFF: heap_q <= pwdata[HEAP_W-1:0];
					REG_INC_SIZE: inc_q  <= pwdata[INC_W-1:0];
					default: begin
					end
				endcase
			end
			vld_s1  <= scan_issue;
			ridx_s1 <= idx_q;
			if (scan_issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						cmd_q       <= cmd;
						head_q      <= req_head;
						size_q      <= (cmd == CMD_RELEASE && req_end > 17'h10000)
							? SLOT_W'(17'h10000 - {1'b0, req_head}) : req_size;
						idx_q       <= '0;
						have_prev_q <= 1'b0;
						have_next_q <= 1'b0;
						res_head_q  <= '0;
						res_size_q  <= '0;
						if (req_size == '0) begin
							res_st_q <= (cmd == CMD_ALLOC) ? ST_ALLOC_FAIL : ST_RELEASED;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (alloc_hit) begin
						res_st_q   <= ST_ALLOC_OK;
						res_head_q <= ent_start;
						res_size_q <= size_q;
						if (alloc_rem == '0) begin
							j_q     <= ridx_s1;
							state_q <= S_SHDN_RD;
						end else begin
							state_q <= S_RESP;
						end
					end else if (rel_found) begin
						pos_q        <= ridx_s1;
						next_start_q <= ent_start;
						next_len_q   <= ent_len;
						have_next_q  <= 1'b1;
						state_q      <= S_DEC;
					end else if (vld_s1) begin
						prev_start_q <= ent_start;
						prev_len_q   <= ent_len;
						have_prev_q  <= 1'b1;
					end else if (scan_end) begin
						if (cmd_q == CMD_ALLOC) begin
							res_st_q <= ST_ALLOC_FAIL;
							state_q  <= S_RESP;
						end else begin
							pos_q   <= count_q;
							state_q <= S_DEC;
						end
					end
				end
				S_DEC: begin
					res_st_q <= ST_RELEASED;
					if (with_prev) begin
						if (with_next) begin
							j_q     <= pos_q;
							state_q <= S_SHDN_RD;
						end else begin
							state_q <= S_RESP;
						end
					end else if (with_next) begin
						state_q <= S_RESP;
					end else if (count_q >= MAX_CNT) begin
						res_st_q <= ST_DROPPED;
						state_q  <= S_RESP;
					end else begin
						j_q     <= count_q;
						state_q <= S_SHUP_RD;
					end
				end
				S_SHDN_RD: begin
					if (j_p1 < count_q) begin
						state_q <= S_SHDN_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_SHDN_WR: begin
					j_q     <= j_p1;
					state_q <= S_SHDN_RD;
				end
				S_SHUP_RD: begin
					if (j_q > pos_q) begin
						state_q <= S_SHUP_WR;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_RESP;
					end
				end
				S_SHUP_WR: begin
					j_q     <= j_m1;
					state_q <= S_SHUP_RD;
				end
				S_RESP: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid   <= 1'b1;
						status      <= res_st_q;
						block_head  <= res_head_q;
						block_size  <= res_size_q;
						byte_offset <= (res_st_q == ST_ALLOC_OK) ? off_prod[OFF_W-1:0] : '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
